@@ rtl/conv3x3_replicate_border_clamp_macros.svh @@
// ---------------------------------------------------------------------------
// conv3x3_replicate_border_clamp_macros.svh
// Assertion shorthands for the checker file of the 3x3 filter.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_REPLICATE_BORDER_CLAMP_MACROS_SVH
`define CONV3X3_REPLICATE_BORDER_CLAMP_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define C3RB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("c3rb assertion failed");

// Clocked assertion that also holds during reset.
`define C3RB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("c3rb assertion failed");

`endif

@@ rtl/c3rb_pkg.sv @@
// ---------------------------------------------------------------------------
// c3rb_pkg
// Types and constants shared by the 3x3 replicate-border filter.
// ---------------------------------------------------------------------------
package c3rb_pkg;

  localparam int PIX_W     = 8;
  localparam int LINES     = 3;
  localparam int TAPS      = 3;
  localparam int COEFF_W   = 16;
  localparam int ROW_W     = TAPS * COEFF_W;
  localparam int PROD_W    = PIX_W + 1 + COEFF_W;   // unsigned pixel times signed coeff
  localparam int SUM_W     = PROD_W + 4;            // nine products plus rounding
  localparam int OUT_SHIFT = 12;
  localparam int OUT_ROUND = 1 << (OUT_SHIFT - 1);
  localparam int PIX_MAX   = (1 << PIX_W) - 1;
  localparam int CFG_IDX_W = 2;

  // Middle row resets to a center tap of 1.0 (4096), a passthrough.
  localparam logic [ROW_W-1:0] ROW_MIDDLE_RST = ROW_W'(4096) << COEFF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_TOP    = 2'd0,
    CFG_ROW_MIDDLE = 2'd1,
    CFG_ROW_BOTTOM = 2'd2
  } cfg_idx_e;

  // One column: line 0 top, 1 middle, 2 bottom.
  typedef logic [LINES-1:0][PIX_W-1:0] col_t;

  // Coefficient bank: row r, tap p at [r][COEFF_W*p +: COEFF_W].
  typedef logic [LINES-1:0][ROW_W-1:0] coeff_bank_t;

  // One 3x3 window: cols[0] left, cols[1] center, cols[2] right.
  typedef struct packed {
    col_t [TAPS-1:0] cols;
    logic            last;
  } win_t;

endpackage

@@ rtl/conv3x3_replicate_border_clamp.sv @@
// ---------------------------------------------------------------------------
// conv3x3_replicate_border_clamp
// Streaming 3x3 convolution over three lines with replicated borders.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one column per transfer (top, middle, bottom pixel) plus
//   line_end_i on the last column of a line. Output channel: one filtered
//   pixel per transfer, line_last_o on the final pixel of each line.
//   The first column of a line yields nothing; every later column yields the
//   pixel to its left; a line end yields one extra pixel for the last column
//   (a one-column line yields a single pixel, the column replicated).
//   Throughput: one column per cycle unless stalled; a line end of two or
//   more columns raises in_stall_o until the second pixel enters the
//   window register.
//   Pipeline: a pixel's window register loads at the transfer of the column
//   that completes its window, followed by the product and result
//   registers.
//   Stalls: out_stall_i holds the result register; the product and
//   window registers fill behind it, and in_stall_o rises once they are
//   full or a second line-end pixel waits. Nothing is dropped or repeated.
//   Configuration: cfg_we_i writes a 48-bit coefficient row (index 0 top,
//   1 middle, 2 bottom; index 3 ignored). Write only while the pipe is empty.
//   Reset: clears the column history to start of line, empties the pipe and
//   loads the passthrough kernel (middle center 4096, all else 0).
// ---------------------------------------------------------------------------
module conv3x3_replicate_border_clamp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [c3rb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [c3rb_pkg::ROW_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     pixel_top_i,
  input  logic [7:0]                     pixel_middle_i,
  input  logic [7:0]                     pixel_bottom_i,
  input  logic                           line_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     filtered_pixel_o,
  output logic                           line_last_o
);
  import c3rb_pkg::*;

  coeff_bank_t coeff_q, coeff_d;
  col_t        col;
  win_t        win;
  logic        win_valid, win_stall;

  // Coefficient rows: decode the index, ignore the unused code.
  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_TOP:    coeff_d[0] = cfg_data_i;
        CFG_ROW_MIDDLE: coeff_d[1] = cfg_data_i;
        CFG_ROW_BOTTOM: coeff_d[2] = cfg_data_i;
        default:        coeff_d    = coeff_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= {ROW_W'(0), ROW_MIDDLE_RST, ROW_W'(0)};
    end else begin
      coeff_q <= coeff_d;
    end
  end

  // Pack the column: line 0 is the top line.
  assign col = {pixel_bottom_i, pixel_middle_i, pixel_top_i};

  c3rb_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .col_i       (col),
    .line_end_i  (line_end_i),
    .win_valid_o (win_valid),
    .win_o       (win),
    .win_stall_i (win_stall)
  );

  c3rb_mac u_mac (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .win_valid_i      (win_valid),
    .win_stall_o      (win_stall),
    .win_i            (win),
    .coeff_i          (coeff_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_pixel_o (filtered_pixel_o),
    .line_last_o      (line_last_o)
  );

endmodule

@@ rtl/c3rb_window.sv @@
// ---------------------------------------------------------------------------
// c3rb_window
// Column history and border sequencing; issues one window per output pixel.
// ---------------------------------------------------------------------------
module c3rb_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  c3rb_pkg::col_t col_i,
  input  logic           line_end_i,
  output logic           win_valid_o,
  output c3rb_pkg::win_t win_o,
  input  logic           win_stall_i
);
  import c3rb_pkg::*;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_MANY
  } seen_e;

  seen_e seen_q, seen_d;
  col_t  older_q, older_d, newer_q, newer_d;
  win_t  win_q, win_d, pend_q, pend_d;
  logic  win_vld_q, win_vld_d, pend_vld_q, pend_vld_d;
  logic  win_free, accept;

  assign win_free    = !win_vld_q || !win_stall_i;
  assign in_stall_o  = !win_free || pend_vld_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign win_valid_o = win_vld_q;
  assign win_o       = win_q;

  always_comb begin
    seen_d     = seen_q;
    older_d    = older_q;
    newer_d    = newer_q;
    win_d      = win_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    win_vld_d  = win_vld_q && !win_free;
    if (pend_vld_q && win_free) begin
      // second pixel of a line end
      win_d      = pend_q;
      win_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end else if (accept) begin
      unique case (seen_q)
        SEEN_NONE: begin
          if (line_end_i) begin
            win_d     = '{cols: {col_i, col_i, col_i}, last: 1'b1};
            win_vld_d = 1'b1;
          end else begin
            newer_d = col_i;
            seen_d  = SEEN_ONE;
          end
        end
        SEEN_ONE, SEEN_MANY: begin
          win_d.cols = {col_i, newer_q, (seen_q == SEEN_ONE) ? newer_q : older_q};
          win_d.last = 1'b0;
          win_vld_d  = 1'b1;
          if (line_end_i) begin
            pend_d     = '{cols: {col_i, col_i, newer_q}, last: 1'b1};
            pend_vld_d = 1'b1;
            seen_d     = SEEN_NONE;
          end else begin
            seen_d = SEEN_MANY;
          end
          older_d = newer_q;
          newer_d = col_i;
        end
        default: seen_d = SEEN_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= SEEN_NONE;
      older_q    <= '0;
      newer_q    <= '0;
      win_q      <= '0;
      pend_q     <= '0;
      win_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
      win_q      <= win_d;
      pend_q     <= pend_d;
      win_vld_q  <= win_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule

@@ rtl/c3rb_mac.sv @@
// ---------------------------------------------------------------------------
// c3rb_mac
// Nine products, then sum, round, shift and clamp into the result register.
// ---------------------------------------------------------------------------
module c3rb_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  win_valid_i,
  output logic                  win_stall_o,
  input  c3rb_pkg::win_t        win_i,
  input  c3rb_pkg::coeff_bank_t coeff_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            filtered_pixel_o,
  output logic                  line_last_o
);
  import c3rb_pkg::*;

  logic signed [PROD_W-1:0] prod_q [LINES][TAPS];
  logic signed [PROD_W-1:0] prod_d [LINES][TAPS];
  logic                     prod_vld_q, prod_last_q;
  logic                     out_vld_q, out_last_q;
  logic [PIX_W-1:0]         out_pix_q, out_pix_d;
  logic                     out_free, prod_free;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign prod_free   = !prod_vld_q || out_free;
  assign win_stall_o = !prod_free;

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      for (int p = 0; p < TAPS; p++) begin
        prod_d[r][p] = PROD_W'($signed({1'b0, win_i.cols[p][r]}))
                     * PROD_W'($signed(coeff_i[r][COEFF_W*p +: COEFF_W]));
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0]    acc;
    logic [SUM_W-OUT_SHIFT-1:0] shifted;
    acc = SUM_W'(OUT_ROUND);
    for (int r = 0; r < LINES; r++) begin
      for (int p = 0; p < TAPS; p++) begin
        acc = acc + SUM_W'(prod_q[r][p]);
      end
    end
    shifted = acc[SUM_W-1:OUT_SHIFT];
    if (acc[SUM_W-1]) begin
      out_pix_d = '0;
    end else if (shifted > (SUM_W-OUT_SHIFT)'(PIX_MAX)) begin
      out_pix_d = PIX_W'(PIX_MAX);
    end else begin
      out_pix_d = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (prod_free) begin
        prod_vld_q <= win_valid_i;
      end
      if (out_free) begin
        out_vld_q <= prod_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_free && win_valid_i) begin
      prod_q      <= prod_d;
      prod_last_q <= win_i.last;
    end
    if (out_free && prod_vld_q) begin
      out_pix_q  <= out_pix_d;
      out_last_q <= prod_last_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign filtered_pixel_o = out_pix_q;
  assign line_last_o      = out_last_q;

endmodule

@@ rtl/c3rb_checker.sv @@
// ---------------------------------------------------------------------------
// c3rb_checker
// Port-level checks of the 3x3 filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "conv3x3_replicate_border_clamp_macros.svh"

module c3rb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       line_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] filtered_pixel_o,
  input logic       line_last_o
);

  // A stalled result holds its value and flag.
  `C3RB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_pixel_o) && $stable(line_last_o))

  // With the result register empty nothing downstream stalls, so input is open
  // unless a line end just queued its second pixel.
  `C3RB_ASSERT(a_no_idle_stall, clk_i, rst_ni, !out_valid_o |-> !in_stall_o || $past(in_valid_i && !in_stall_o && line_end_i))

  // Reset empties the result register and keeps the input stall low.
  `C3RB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule

bind conv3x3_replicate_border_clamp c3rb_checker u_c3rb_checker (.*);
